// ===== sv/numeric_format_converter_macros.svh =====
// Assertion macros shared by the converter RTL.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef NUMERIC_FORMAT_CONVERTER_MACROS_SVH
`define NUMERIC_FORMAT_CONVERTER_MACROS_SVH

// Same-cycle implication
`define NFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define NFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/nfc_pkg.sv =====
// Shared types and codes for the numeric format converter.
// No dependencies.
package nfc_pkg;

  // Type codes on source_type / target_type
  localparam logic [2:0] TY_I32  = 3'd0;
  localparam logic [2:0] TY_I64  = 3'd1;
  localparam logic [2:0] TY_F32  = 3'd2;
  localparam logic [2:0] TY_F64  = 3'd3;
  localparam logic [2:0] TY_BOOL = 3'd4;

  // What the back end of the pipe does with a transaction
  typedef enum logic [1:0] {
    K_PASS,   // mag already holds the final result
    K_RND,    // round mag * 2^e into a float
    K_F2I     // shift significand, then apply sign
  } nfc_kind_t;

  // Per-transaction pipeline payload
  typedef struct packed {
    nfc_kind_t          kind;
    logic               conv;
    logic               narrow;   // 32-bit result
    logic               dbl;      // float target is binary64
    logic               neg;
    logic [63:0]        mag;
    logic signed [12:0] e;
    logic signed [12:0] ex;
    logic [5:0]         p;
    logic               zero;
    logic               tiny;
    logic               shl;
    logic               big;
    logic [6:0]         amt;
    logic               guard;
    logic               sticky;
  } nfc_item_t;

endpackage

// ===== sv/nfc_decode.sv =====
// Front-end decode: classifies the type pair and unpacks the source value.
// Depends on nfc_pkg.
module nfc_decode import nfc_pkg::*; (
  input  logic [63:0] value_bits,
  input  logic [2:0]  source_type,
  input  logic [2:0]  target_type,
  output nfc_item_t   item
);

  logic [31:0]        lo;
  logic [63:0]        sx;
  logic [63:0]        ival;
  logic               sdbl;
  logic [10:0]        expf;
  logic [51:0]        frac;
  logic               sgn;
  logic               emax;
  logic signed [12:0] fex;
  logic [6:0]         m7;
  logic [6:0]         w7;
  logic [63:0]        maxv;
  logic [63:0]        minv;

  assign lo = value_bits[31:0];
  assign sx = {{32{lo[31]}}, lo};

  always_comb begin
    item        = '0;
    item.kind   = K_PASS;
    sdbl        = (source_type == TY_F64);
    sgn         = sdbl ? value_bits[63] : lo[31];
    expf        = sdbl ? value_bits[62:52] : {3'b0, lo[30:23]};
    frac        = sdbl ? value_bits[51:0] : {29'b0, lo[22:0]};
    emax        = sdbl ? (expf == 11'h7FF) : (expf == 11'h0FF);
    fex         = $signed({2'b0, expf}) - (sdbl ? 13'sd1023 : 13'sd127);
    m7          = sdbl ? 7'd52 : 7'd23;
    w7          = (target_type == TY_I64) ? 7'd64 : 7'd32;
    maxv        = (target_type == TY_I64) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
    minv        = (target_type == TY_I64) ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    ival        = (source_type == TY_I32) ? sx : value_bits;

    if (source_type > TY_BOOL || target_type > TY_BOOL) begin
      item.conv = 1'b0;
    end else if (source_type == target_type) begin
      item.conv = 1'b1;
      item.mag  = value_bits;
    end else if (source_type == TY_BOOL || target_type == TY_BOOL) begin
      item.conv = 1'b0;
    end else begin
      item.conv   = 1'b1;
      item.narrow = (target_type == TY_I32) || (target_type == TY_F32);
      item.dbl    = (target_type == TY_F64);
      if (source_type == TY_I32 && target_type == TY_I64) begin
        item.mag = sx;
      end else if (source_type == TY_I64 && target_type == TY_I32) begin
        item.mag = {32'b0, lo};
      end else if (source_type == TY_I32 || source_type == TY_I64) begin
        // integer to float
        item.kind = K_RND;
        item.neg  = ival[63];
        item.mag  = ival[63] ? (64'd0 - ival) : ival;
        item.e    = '0;
      end else if (target_type == TY_F32 || target_type == TY_F64) begin
        // float to float
        if (emax) begin
          if (sdbl) begin
            item.mag = {32'b0, sgn, 31'h7F80_0000 |
                        ((frac != '0) ? {8'h00, 1'b1, frac[50:29]} : 31'h0)};
          end else begin
            item.mag = {sgn, 63'h7FF0_0000_0000_0000 |
                        ((frac != '0) ? {11'h000, 1'b1, frac[21:0], 29'b0} : 63'h0)};
          end
        end else begin
          item.kind = K_RND;
          item.neg  = sgn;
          if (expf == '0) begin
            item.mag = {12'b0, frac};
            item.e   = sdbl ? -13'sd1074 : -13'sd149;
          end else begin
            item.mag = sdbl ? {11'b0, 1'b1, frac} : {40'b0, 1'b1, frac[22:0]};
            item.e   = $signed({2'b0, expf}) - (sdbl ? 13'sd1075 : 13'sd150);
          end
        end
      end else begin
        // float to integer, truncating
        if (emax) begin
          item.mag = (frac != '0) ? 64'd0 : (sgn ? minv : maxv);
        end else if (expf == '0 || fex < 13'sd0) begin
          item.mag = '0;
        end else if (fex >= $signed({6'b0, w7}) - 13'sd1) begin
          item.mag = sgn ? minv : maxv;
        end else begin
          item.kind = K_F2I;
          item.neg  = sgn;
          item.mag  = sdbl ? {11'b0, 1'b1, frac} : {40'b0, 1'b1, frac[22:0]};
          item.shl  = (fex >= $signed({6'b0, m7}));
          item.amt  = item.shl ? (fex[6:0] - m7) : (m7 - fex[6:0]);
        end
      end
    end
  end

endmodule

// ===== sv/numeric_format_converter.sv =====
// Top level of the numeric format converter: five-stage conversion pipe.
// Depends on nfc_pkg, nfc_decode and numeric_format_converter_macros.svh.
//
//   channel | handshake            | payload
//   input   | in_valid / in_stall   | value_bits, source_type, target_type
//   output  | out_valid / out_stall | result_bits, converted
//
// One transaction per cycle unless a stall holds it; the stages are decode,
// leading-one search, exponent math, alignment shift, round and pack.
// Reset clears the stage valid bits only.
// A stall holds only the stages that are full behind it; bubbles close up,
// so the input keeps taking transactions while a result waits, until every stage is full.
`include "numeric_format_converter_macros.svh"

module numeric_format_converter import nfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value_bits,
  input  logic [2:0]  source_type,
  input  logic [2:0]  target_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_bits,
  output logic        converted
);

  nfc_item_t d0, s1, s2, s3, s4, s5;
  nfc_item_t s2_next, s3_next, s4_next, s5_next;
  logic      v1, v2, v3, v4, v5;
  logic      rdy1, rdy2, rdy3, rdy4, rdy5;

  nfc_decode u_dec (
    .value_bits  (value_bits),
    .source_type (source_type),
    .target_type (target_type),
    .item        (d0)
  );

  // Stage ready chain
  assign rdy5     = !v5 || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  // Leading one of the magnitude
  always_comb begin
    s2_next      = s1;
    s2_next.p    = '0;
    s2_next.zero = (s1.mag == '0);
    for (int i = 0; i < 64; i++) begin
      if (s1.mag[i]) s2_next.p = 6'(i);
    end
  end

  // Exponent, subnormal check and alignment amount
  logic signed [12:0] emin, mant, q, sh;
  always_comb begin
    s3_next = s2;
    emin    = s2.dbl ? -13'sd1022 : -13'sd126;
    mant    = s2.dbl ? 13'sd52 : 13'sd23;
    s3_next.ex   = $signed({7'b0, s2.p}) + s2.e;
    s3_next.tiny = s3_next.ex < emin;
    q  = s3_next.tiny ? (emin - mant) : (s3_next.ex - mant);
    sh = q - s2.e;
    if (s2.kind == K_RND) begin
      s3_next.shl = (sh <= 13'sd0);
      s3_next.big = (sh > 13'sd64);
      s3_next.amt = s3_next.shl ? 7'(-sh) : (s3_next.big ? 7'd64 : sh[6:0]);
    end
  end

  // Alignment shift with guard and sticky
  logic [6:0]  am1;
  logic [63:0] lowmask;
  always_comb begin
    s4_next        = s3;
    s4_next.guard  = 1'b0;
    s4_next.sticky = 1'b0;
    am1            = s3.amt - 7'd1;
    lowmask        = (64'd1 << am1[5:0]) - 64'd1;
    if (s3.kind != K_PASS) begin
      if (s3.shl) begin
        s4_next.mag = s3.mag << s3.amt;
      end else if (s3.big) begin
        s4_next.mag = '0;
      end else begin
        s4_next.mag = s3.mag >> s3.amt;
        if (s3.amt != '0) begin
          s4_next.guard  = s3.mag[am1[5:0]];
          s4_next.sticky = (s3.mag & lowmask) != '0;
        end
      end
    end
  end

  // Round, pack and saturate
  logic [63:0] kept, enc, top, sb;
  logic [12:0] biased;
  always_comb begin
    s5_next = s4;
    kept    = s4.mag + {63'b0, s4.guard && (s4.sticky || s4.mag[0])};
    top     = s4.dbl ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
    sb      = s4.neg ? (s4.dbl ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000) : '0;
    biased  = 13'(s4.ex + (s4.dbl ? 13'sd1022 : 13'sd126));
    enc     = s4.tiny ? kept :
              (({51'b0, biased} << (s4.dbl ? 7'd52 : 7'd23)) + kept);
    if (enc >= top) enc = top;
    case (s4.kind)
      K_RND:   s5_next.mag = s4.zero ? sb : (sb | enc);
      K_F2I: begin
        s5_next.mag = s4.neg ? (64'd0 - s4.mag) : s4.mag;
        if (s4.narrow) s5_next.mag[63:32] = '0;
      end
      default: s5_next.mag = s4.mag;
    endcase
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= d0;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
    if (rdy4) s4 <= s4_next;
    if (rdy5) s5 <= s5_next;
  end

  assign out_valid   = v5;
  assign result_bits = s5.mag;
  assign converted   = s5.conv;

  `NFC_ASSERT_IMP(a_refused_zero, out_valid && !converted, result_bits == 64'd0, "refused transaction with nonzero result")
  `NFC_ASSERT_IMP(a_narrow_upper, out_valid && s5.narrow, result_bits[63:32] == 32'd0, "32-bit result with upper bits set")
  `NFC_ASSERT_NXT(a_advance, v4 && rdy5, out_valid, "stage four transaction lost")

endmodule

// ===== test/nfc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the numeric format converter: watches both channels, predicts
// each result from the accepted transaction and compares. Depends on nfc_pkg.
module nfc_checker import nfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] value_bits,
  input  logic [2:0]  source_type,
  input  logic [2:0]  target_type,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] result_bits,
  input  logic        converted,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [63:0] bits;
    logic        ok;
  } conv_result_t;

  conv_result_t awaited_q[$];

  // Round (neg, mag * 2^e) to a float with mb fraction and eb exponent bits.
  function automatic logic [63:0] pack_rounded(logic neg, logic [63:0] mag, int e,
                                               int mb, int eb);
    logic [63:0] sgn, kept, enc, top, rem, half;
    int p, bias, emin, ex, q, sh;
    sgn = neg ? (64'd1 << (mb + eb)) : 64'd0;
    if (mag == 0) return sgn;
    p = 63;
    while (!mag[p]) p--;
    bias = (1 << (eb - 1)) - 1;
    emin = 1 - bias;
    ex = p + e;
    q = (ex < emin) ? emin - mb : ex - mb;
    sh = q - e;
    if (sh <= 0) begin
      kept = (-sh < 64) ? (mag << (-sh)) : 64'd0;
    end else if (sh > 64) begin
      kept = 0;
    end else begin
      if (sh == 64) begin
        kept = 0;
        rem = mag;
        half = 64'd1 << 63;
      end else begin
        kept = mag >> sh;
        rem = mag & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
      end
      if (rem > half || (rem == half && kept[0])) kept++;
    end
    top = ((64'd1 << eb) - 1) << mb;
    enc = (ex < emin) ? kept : ((64'(ex + bias - 1)) << mb) + kept;
    if (enc >= top) enc = top;
    return sgn | enc;
  endfunction

  // Truncating float to w-bit integer with saturation; NaN gives zero.
  function automatic logic [63:0] float_to_sat_int(logic [63:0] b, int mb, int eb,
                                                   int w);
    logic [63:0] emask, mmask, expf, frac, wmask, minv, maxv, sig, mag;
    logic neg;
    int ex;
    emask = (64'd1 << eb) - 1;
    mmask = (64'd1 << mb) - 1;
    neg = b[mb + eb];
    expf = (b >> mb) & emask;
    frac = b & mmask;
    wmask = (w == 64) ? '1 : 64'hFFFF_FFFF;
    minv = 64'd1 << (w - 1);
    maxv = minv - 1;
    if (expf == emask) return (frac != 0) ? 64'd0 : (neg ? minv : maxv);
    if (expf == 0) return 0;
    ex = int'(expf) - ((1 << (eb - 1)) - 1);
    if (ex < 0) return 0;
    if (ex >= w - 1) return neg ? minv : maxv;
    sig = frac | (64'd1 << mb);
    mag = (ex >= mb) ? (sig << (ex - mb)) : (sig >> (mb - ex));
    return (neg ? (64'd0 - mag) : mag) & wmask;
  endfunction

  function automatic logic [63:0] int_to_float(logic [63:0] v, int w, int mb, int eb);
    logic neg;
    logic [63:0] sx;
    neg = v[w - 1];
    sx = (w == 32 && neg) ? (v | 64'hFFFF_FFFF_0000_0000) : v;
    return pack_rounded(neg, neg ? (64'd0 - sx) : sx, 0, mb, eb);
  endfunction

  function automatic conv_result_t convert(logic [63:0] v, logic [2:0] src,
                                           logic [2:0] dst);
    conv_result_t r;
    logic [63:0] lo, fr;
    logic [63:0] sb;
    lo = {32'd0, v[31:0]};
    r.ok = 1;
    r.bits = 0;
    if (src > TY_BOOL || dst > TY_BOOL) begin
      r.ok = 0;
    end else if (src == dst) begin
      r.bits = v;
    end else if (src == TY_BOOL || dst == TY_BOOL) begin
      r.ok = 0;
    end else begin
      case (src)
        TY_I32: begin
          if (dst == TY_I64) r.bits = {{32{v[31]}}, v[31:0]};
          else if (dst == TY_F32) r.bits = int_to_float(lo, 32, 23, 8);
          else r.bits = int_to_float(lo, 32, 52, 11);
        end
        TY_I64: begin
          if (dst == TY_I32) r.bits = lo;
          else if (dst == TY_F32) r.bits = int_to_float(v, 64, 23, 8);
          else r.bits = int_to_float(v, 64, 52, 11);
        end
        TY_F32: begin
          if (dst == TY_I32) r.bits = float_to_sat_int(lo, 23, 8, 32);
          else if (dst == TY_I64) r.bits = float_to_sat_int(lo, 23, 8, 64);
          else begin
            sb = {v[31], 63'd0};
            fr = {41'd0, v[22:0]};
            if (v[30:23] == 8'hFF)
              r.bits = sb | 64'h7FF0_0000_0000_0000 |
                       ((fr != 0) ? (64'h0008_0000_0000_0000 | (fr << 29)) : 64'd0);
            else if (v[30:23] == 0) r.bits = pack_rounded(v[31], fr, -149, 52, 11);
            else r.bits = pack_rounded(v[31], fr | 64'h80_0000,
                                       int'(v[30:23]) - 150, 52, 11);
          end
        end
        default: begin
          if (dst == TY_I32) r.bits = float_to_sat_int(v, 52, 11, 32);
          else if (dst == TY_I64) r.bits = float_to_sat_int(v, 52, 11, 64);
          else begin
            sb = {32'd0, v[63], 31'd0};
            fr = {12'd0, v[51:0]};
            if (v[62:52] == 11'h7FF)
              r.bits = sb | 64'h7F80_0000 |
                       ((fr != 0) ? (64'h40_0000 | (fr >> 29)) : 64'd0);
            else if (v[62:52] == 0) r.bits = pack_rounded(v[63], fr, -1074, 23, 8);
            else r.bits = pack_rounded(v[63], fr | (64'd1 << 52),
                                       int'(v[62:52]) - 1075, 23, 8);
          end
        end
      endcase
    end
    return r;
  endfunction

  assign pending = awaited_q.size();

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    conv_result_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        awaited_q.push_back(convert(value_bits, source_type, target_type));
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          $error("result with no transaction outstanding: %h", result_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_q.pop_front();
          if (result_bits !== want.bits || converted !== want.ok) begin
            if (result_bits !== want.bits)
              $error("result_bits expected %h actual %h", want.bits, result_bits);
            if (converted !== want.ok)
              $error("converted expected %b actual %b", want.ok, converted);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_numeric_format_converter.sv =====
`timescale 1ns / 1ps
// Testbench top for the numeric format converter: drives directed and random
// transactions with random idling and stalls. Depends on nfc_pkg, nfc_checker.
module tb_numeric_format_converter;
  import nfc_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [63:0] value_bits = 0;
  logic [2:0]  source_type = TY_I32;
  logic [2:0]  target_type = TY_I32;
  logic        out_valid;
  logic        out_stall = 0;
  logic [63:0] result_bits;
  logic        converted;
  int          fail_count;
  int          pending;
  logic        busy_phase = 1;

  always #1 clk = ~clk;

  numeric_format_converter dut (.*);

  nfc_checker chk (.*);

  // Interesting operand values
  function automatic logic [63:0] pick_value(logic [2:0] src);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: r = 64'h7FF0_0000_0000_0000 | (($urandom_range(0, 1)) ? r[51:0] : 0) |
             {r[63], 63'd0};
      1: r = {r[63:32], r[31], 8'hFF, (($urandom_range(0, 1)) ? r[22:0] : 23'd0)};
      2: r = {r[63], 11'd0, r[51:0]};
      3: r = {r[63:32], r[31], 8'd0, r[22:0]};
      4: r = {r[63], 11'(1023 + $urandom_range(0, 70)), r[51:0]};
      5: r = {r[63:32], r[31], 8'(127 + $urandom_range(0, 70)), r[22:0]};
      6: r = r >> $urandom_range(0, 63);
      7: r = 64'd0 - (r >> $urandom_range(0, 63));
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(logic [63:0] v, logic [2:0] s, logic [2:0] t);
    while (!busy_phase && $urandom_range(0, 99) < 18) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    value_bits <= v;
    source_type <= s;
    target_type <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stalls, with an initial stretch of none
  always @(posedge clk) out_stall <= !busy_phase && ($urandom_range(0, 99) < 18);

  initial begin
    logic [63:0] edge_vals[10];
    logic [2:0] s, t;
    edge_vals = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'h8000_0000, 64'h7FFF_FFFF, 64'h7F80_0001, 64'h7FF0_0000_0000_0001,
                  64'h4F00_0000, 64'h43E0_0000_0000_0000};
    repeat (9) @(posedge clk);
    rst <= 0;
    // Directed: extremes across a spread of type pairs
    for (int i = 0; i < 25; i++)
      send(edge_vals[i % 10], 3'(i % 8), 3'((i * 3 + i / 8) % 8));
    for (int i = 0; i < 550; i++) begin
      if (i == 120) busy_phase <= 0;
      s = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      t = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      send(pick_value(s), s, t);
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("numeric_format_converter verification clean");
    else
      $display("numeric_format_converter verification failed");
    $finish;
  end

  initial begin
    #200000;
    $display("numeric_format_converter verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/nfc_pkg.sv
sv/nfc_decode.sv
sv/numeric_format_converter.sv
test/nfc_checker.sv
test/tb_numeric_format_converter.sv
